FILE: hdl/baa_pkg.sv
// shared types, constants and codes of the bump arena allocator
`default_nettype none

package baa_pkg;

    // word layouts
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;

    // action codes (input tuser)
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_GRANT  = 2'd1;
    localparam logic [1:0] ACT_REWIND = 2'd2;

    // status codes (output tuser)
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NEED      = 2'd1;
    localparam logic [1:0] ST_OOM       = 2'd2;
    localparam logic [1:0] ST_NO_PEND   = 2'd3;

    // register indexes (paddr[2])
    localparam logic REG_MIN_ALIGN = 1'b0;
    localparam logic REG_LIMIT     = 1'b1;

    // arena constants
    localparam logic [31:0] FOOTER_BYTES      = 32'd48;
    localparam logic [31:0] BASE_CHUNK_BYTES  = 32'd4096;
    localparam logic [31:0] MIN_CHUNK_USABLE  = BASE_CHUNK_BYTES - FOOTER_BYTES;
    localparam logic [4:0]  CHUNK_ALIGN_LOG2  = 5'd4;
    localparam logic [31:0] CHUNK_ALIGN_MASK  = 32'd15;
    localparam logic [2:0]  MAX_MIN_ALIGN_LOG2 = 3'd4;
    localparam logic [31:0] NO_LIMIT          = 32'hFFFF_FFFF;

    // datapath operations
    typedef logic [4:0] t_op;
    localparam t_op OP_NONE     = 5'd0;
    localparam t_op OP_LOAD     = 5'd1;
    localparam t_op OP_ZERO     = 5'd2;
    localparam t_op OP_NO_PEND  = 5'd3;
    localparam t_op OP_REFUSE   = 5'd4;
    localparam t_op OP_INSTALL  = 5'd5;
    localparam t_op OP_SUM      = 5'd6;
    localparam t_op OP_SETBUMP  = 5'd7;
    localparam t_op OP_REWIND   = 5'd8;
    localparam t_op OP_RND      = 5'd9;
    localparam t_op OP_SUB      = 5'd10;
    localparam t_op OP_FIT      = 5'd11;
    localparam t_op OP_OOM      = 5'd12;
    localparam t_op OP_PREV     = 5'd13;
    localparam t_op OP_DBL      = 5'd14;
    localparam t_op OP_RS       = 5'd15;
    localparam t_op OP_LIM      = 5'd16;
    localparam t_op OP_US       = 5'd17;
    localparam t_op OP_TOT      = 5'd18;
    localparam t_op OP_TALIGN   = 5'd19;
    localparam t_op OP_COMMIT   = 5'd20;
    localparam t_op OP_OUT      = 5'd21;

    // configuration seen by the datapath
    typedef struct packed {
        logic [2:0]  min_align_log2;
        logic [31:0] byte_cap;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        t_op op;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] act;
        logic       req_zero;
        logic       have;
        logic       pending;
        logic       base_zero;
        logic       fail;
        logic       fit;
    } t_sts;

    // mask of the low lg bits
    function automatic logic [31:0] lo_mask(input logic [4:0] lg);
        lo_mask = ~(32'hFFFF_FFFF << lg);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/baa_ctrl.sv
// sequencer of the bump arena allocator: handshakes and step order
`default_nettype none

module baa_ctrl import baa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DEC     = 5'd1;
    localparam logic [4:0] S_SUM     = 5'd2;
    localparam logic [4:0] S_SETBUMP = 5'd3;
    localparam logic [4:0] S_RND     = 5'd4;
    localparam logic [4:0] S_REWIND  = 5'd5;
    localparam logic [4:0] S_SUB     = 5'd6;
    localparam logic [4:0] S_FIT     = 5'd7;
    localparam logic [4:0] S_PREV    = 5'd8;
    localparam logic [4:0] S_DBL     = 5'd9;
    localparam logic [4:0] S_RS      = 5'd10;
    localparam logic [4:0] S_LIM     = 5'd11;
    localparam logic [4:0] S_US      = 5'd12;
    localparam logic [4:0] S_TOT     = 5'd13;
    localparam logic [4:0] S_TALIGN  = 5'd14;
    localparam logic [4:0] S_COMMIT  = 5'd15;
    localparam logic [4:0] S_FIN     = 5'd16;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // step order
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NONE;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.act)
                    ACT_ALLOC: begin
                        if (i_sts.req_zero) begin
                            o_cmd.op = OP_ZERO;
                            n_state  = S_FIN;
                        end else begin
                            o_cmd.op = OP_RND;
                            n_state  = i_sts.have ? S_SUB : S_PREV;
                        end
                    end
                    ACT_GRANT: begin
                        if (!i_sts.pending) begin
                            o_cmd.op = OP_NO_PEND;
                            n_state  = S_FIN;
                        end else if (i_sts.base_zero) begin
                            o_cmd.op = OP_REFUSE;
                            n_state  = S_FIN;
                        end else begin
                            o_cmd.op = OP_INSTALL;
                            n_state  = S_SUM;
                        end
                    end
                    ACT_REWIND: begin
                        if (i_sts.have) begin
                            o_cmd.op = OP_SUM;
                            n_state  = S_REWIND;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_SETBUMP;
            end
            S_SETBUMP: begin
                o_cmd.op = OP_SETBUMP;
                n_state  = S_RND;
            end
            S_RND: begin
                o_cmd.op = OP_RND;
                n_state  = S_SUB;
            end
            S_REWIND: begin
                o_cmd.op = OP_REWIND;
                n_state  = S_FIN;
            end
            S_SUB: begin
                if (i_sts.fail) begin
                    o_cmd.op = OP_OOM;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_SUB;
                    n_state  = S_FIT;
                end
            end
            S_FIT: begin
                if (i_sts.fit) begin
                    o_cmd.op = OP_FIT;
                    n_state  = S_FIN;
                end else if (i_sts.act == ACT_GRANT) begin
                    o_cmd.op = OP_OOM;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_PREV;
                    n_state  = S_DBL;
                end
            end
            S_PREV: begin
                o_cmd.op = OP_PREV;
                n_state  = S_DBL;
            end
            S_DBL: begin
                o_cmd.op = OP_DBL;
                n_state  = S_RS;
            end
            S_RS: begin
                o_cmd.op = OP_RS;
                n_state  = S_LIM;
            end
            S_LIM: begin
                o_cmd.op = OP_LIM;
                n_state  = S_US;
            end
            S_US: begin
                o_cmd.op = OP_US;
                n_state  = S_TOT;
            end
            S_TOT: begin
                o_cmd.op = OP_TOT;
                n_state  = S_TALIGN;
            end
            S_TALIGN: begin
                o_cmd.op = OP_TALIGN;
                n_state  = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.op = OP_COMMIT;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // move the result into the output register once it is free
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

FILE: hdl/baa_dp.sv
// datapath of the bump arena allocator: arena state, pending request, arithmetic
`default_nettype none

module baa_dp import baa_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire t_cmd                  i_cmd,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [1:0]            i_s_tuser,
    output logic      [M_TDATA_W-1:0]  o_m_tdata,
    output logic      [1:0]            o_m_tuser,
    output t_sts                       o_sts
);

    // arena state
    logic [31:0] r_cs, r_bump, r_total, r_usable, r_alloc;
    logic        r_have;
    // pending request
    logic        r_pv;
    logic [31:0] r_psize, r_pusable, r_ptotal;
    logic [4:0]  r_palign;
    // working registers of the current word
    logic [1:0]  r_act;
    logic        r_req_zero;
    logic [31:0] r_sz, r_base;
    logic [4:0]  r_al;
    logic [31:0] r_asz, r_end, r_res, r_tmp, r_nsz, r_rem, r_us;
    logic        r_borrow, r_fail;
    // result and output registers
    logic [1:0]  r_status, r_o_status;
    logic [31:0] r_addr, r_need, r_o_addr, r_o_need, r_o_bytes;
    logic [4:0]  r_nlg, r_o_nlg;

    logic [4:0]  w_ml, w_rl, w_cl;
    logic [31:0] w_rl_mask, w_cl_mask, w_al_mask, w_ml_mask;
    logic [32:0] w_rnd_sum, w_sub, w_us_sum, w_tot_sum, w_ta_sum;
    logic [31:0] w_prev, w_dbl, w_rem;
    logic        w_fit;

    // alignment selection and the single add of each step
    always_comb begin
        w_ml      = (i_cfg.min_align_log2 > MAX_MIN_ALIGN_LOG2) ?
                    {2'b00, MAX_MIN_ALIGN_LOG2} : {2'b00, i_cfg.min_align_log2};
        w_rl      = (r_al > w_ml) ? r_al : w_ml;
        w_cl      = (w_rl > CHUNK_ALIGN_LOG2) ? w_rl : CHUNK_ALIGN_LOG2;
        w_rl_mask = lo_mask(w_rl);
        w_cl_mask = lo_mask(w_cl);
        w_al_mask = lo_mask(r_al);
        w_ml_mask = lo_mask(w_ml);
        w_rnd_sum = {1'b0, r_sz} + {1'b0, w_rl_mask};
        w_sub     = {1'b0, r_end} - {1'b0, r_asz};
        w_fit     = !r_borrow && (r_res >= r_cs);
        w_prev    = (r_have && (r_total >= FOOTER_BYTES)) ? (r_total - FOOTER_BYTES) : 32'd0;
        w_dbl     = r_tmp[31] ? 32'hFFFF_FFFF : {r_tmp[30:0], 1'b0};
        w_rem     = (i_cfg.byte_cap > r_alloc) ?
                    (i_cfg.byte_cap - r_alloc) : 32'd0;
        w_us_sum  = {1'b0, r_nsz} + {1'b0, CHUNK_ALIGN_MASK};
        w_tot_sum = {1'b0, r_us} + {1'b0, FOOTER_BYTES};
        w_ta_sum  = {1'b0, r_tmp} + {1'b0, w_cl_mask};
    end

    // step execution
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs       <= '0;
            r_bump     <= '0;
            r_total    <= '0;
            r_usable   <= '0;
            r_alloc    <= '0;
            r_have     <= 1'b0;
            r_pv       <= 1'b0;
            r_psize    <= '0;
            r_palign   <= '0;
            r_pusable  <= '0;
            r_ptotal   <= '0;
            r_act      <= ACT_ALLOC;
            r_req_zero <= 1'b0;
            r_fail     <= 1'b0;
            r_borrow   <= 1'b0;
            r_status   <= ST_OK;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_act      <= i_s_tuser;
                    r_req_zero <= (i_s_tdata[31:0] == 32'd0);
                    r_sz       <= (i_s_tuser == ACT_GRANT) ? r_psize : i_s_tdata[31:0];
                    r_al       <= (i_s_tuser == ACT_GRANT) ? r_palign : i_s_tdata[36:32];
                    r_base     <= i_s_tdata[68:37];
                    r_fail     <= 1'b0;
                    r_status   <= ST_OK;
                    r_addr     <= '0;
                    r_need     <= '0;
                    r_nlg      <= '0;
                end
                OP_ZERO: begin
                    r_addr <= r_bump & ~w_al_mask;
                end
                OP_NO_PEND: begin
                    r_status <= ST_NO_PEND;
                end
                OP_REFUSE: begin
                    r_pv     <= 1'b0;
                    r_status <= ST_OOM;
                end
                OP_INSTALL: begin
                    r_pv     <= 1'b0;
                    r_cs     <= r_base;
                    r_usable <= r_pusable;
                    r_total  <= r_ptotal;
                    r_alloc  <= r_alloc + r_pusable;
                    r_have   <= 1'b1;
                end
                OP_SUM: begin
                    r_tmp <= r_cs + r_usable;
                end
                OP_SETBUMP: begin
                    r_bump <= r_tmp & ~w_ml_mask;
                end
                OP_REWIND: begin
                    r_bump  <= r_tmp & ~w_ml_mask;
                    r_alloc <= r_usable;
                end
                // rounded size and end of the free region
                OP_RND: begin
                    r_asz  <= w_rnd_sum[31:0] & ~w_rl_mask;
                    r_fail <= w_rnd_sum[32];
                    r_end  <= (r_al <= w_ml) ? r_bump : (r_bump & ~w_al_mask);
                end
                OP_SUB: begin
                    r_borrow <= w_sub[32];
                    r_res    <= w_sub[31:0];
                end
                OP_FIT: begin
                    r_bump <= r_res;
                    r_addr <= r_res;
                end
                OP_OOM: begin
                    r_status <= ST_OOM;
                    r_addr   <= '0;
                end
                // new chunk sizing
                OP_PREV: begin
                    r_tmp <= w_prev;
                end
                OP_DBL: begin
                    r_nsz <= (w_dbl < MIN_CHUNK_USABLE) ? MIN_CHUNK_USABLE : w_dbl;
                end
                OP_RS: begin
                    r_nsz <= (r_nsz < r_asz) ? r_asz : r_nsz;
                    r_rem <= w_rem;
                end
                OP_LIM: begin
                    if ((i_cfg.byte_cap != NO_LIMIT) && (r_nsz > r_rem)) begin
                        if (r_asz > r_rem) begin
                            r_fail <= 1'b1;
                        end else begin
                            r_nsz <= r_asz;
                        end
                    end
                end
                OP_US: begin
                    r_us <= w_us_sum[31:0] & ~CHUNK_ALIGN_MASK;
                    if (w_us_sum[32]) begin
                        r_fail <= 1'b1;
                    end
                end
                OP_TOT: begin
                    r_tmp <= w_tot_sum[31:0];
                    if (w_tot_sum[32]) begin
                        r_fail <= 1'b1;
                    end
                end
                OP_TALIGN: begin
                    r_tmp <= w_ta_sum[31:0] & ~w_cl_mask;
                    if (w_ta_sum[32] || ((w_ta_sum[31:0] & ~w_cl_mask) == 32'd0)) begin
                        r_fail <= 1'b1;
                    end
                end
                OP_COMMIT: begin
                    if (r_fail) begin
                        r_status <= ST_OOM;
                    end else begin
                        r_status  <= ST_NEED;
                        r_need    <= r_tmp;
                        r_nlg     <= w_cl;
                        r_pv      <= 1'b1;
                        r_psize   <= r_sz;
                        r_palign  <= r_al;
                        r_pusable <= r_us;
                        r_ptotal  <= r_tmp;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_o_status <= r_status;
            r_o_addr   <= r_addr;
            r_o_need   <= r_need;
            r_o_nlg    <= r_nlg;
            r_o_bytes  <= r_alloc;
        end
    end

    assign o_m_tdata = {3'b000, r_o_bytes, r_o_nlg, r_o_need, r_o_addr};
    assign o_m_tuser = r_o_status;

    // status toward the sequencer
    always_comb begin
        o_sts.act       = r_act;
        o_sts.req_zero  = r_req_zero;
        o_sts.have      = r_have;
        o_sts.pending   = r_pv;
        o_sts.base_zero = (r_base == 32'd0);
        o_sts.fail      = r_fail;
        o_sts.fit       = w_fit;
    end

endmodule

`default_nettype wire

FILE: hdl/bump_arena_allocator.sv
// bump arena allocator: one word in, one result word out, one word at a time
// the next word enters while a result waits in the output register
// reset (synchronous, active low) empties the arena, drops the pending request,
// sets min_align_log2 to 0 and the byte cap to all ones
`default_nettype none

module bump_arena_allocator import baa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // request_bytes[31:0], align_log2[36:32], chunk_base[68:37], zero fill
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // action[1:0]
    input  wire logic [1:0]           i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // address[31:0], chunk_bytes_needed[63:32], chunk_align_log2[68:64],
    // bytes_in_use[100:69], zero fill
    output logic      [M_TDATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic      [1:0]           o_m_tuser,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    logic [2:0]  r_min_align;
    logic [31:0] r_limit;
    t_cfg        w_cfg;
    t_cmd        w_cmd;
    t_sts        w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_align <= '0;
            r_limit     <= NO_LIMIT;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MIN_ALIGN) begin
                r_min_align <= pwdata[2:0];
            end else begin
                r_limit <= pwdata;
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? r_limit : {29'd0, r_min_align};

    assign w_cfg.min_align_log2 = r_min_align;
    assign w_cfg.byte_cap       = r_limit;

    baa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    baa_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_cmd     (w_cmd),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_sts     (w_sts)
    );

endmodule

`default_nettype wire

FILE: hdl/baa_checker.sv
// port-level checks of the bump arena allocator and their binding
`default_nettype none

module baa_checker import baa_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_tvalid,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic [1:0]           o_m_tuser
);

    // one word at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("word accepted back to back");

    // any status but ok carries a zero address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_OK)) |-> (o_m_tdata[31:0] == 32'd0))
        else $error("address set on a failed word");

    // a chunk request asks at least the chunk alignment; other words ask nothing
    a_need_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == ST_NEED) ? (o_m_tdata[68:64] >= CHUNK_ALIGN_LOG2)
                        : ((o_m_tdata[63:32] == 32'd0) && (o_m_tdata[68:64] == 5'd0))))
        else $error("chunk request fields wrong");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result word changed");

endmodule

bind bump_arena_allocator baa_checker u_baa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
